// File: rtl/rws_pkg.sv
// Package for the roulette-wheel selector: default sizes, command and status
// codes, and sequencer state types. No dependencies.
`timescale 1ns / 1ps

package rws_pkg;

    localparam int DEF_MAX_POPULATION = 256;
    localparam int DEF_FITNESS_BITS   = 16;
    localparam int FRAC_W             = 32;
    localparam int INDEX_W            = 8;
    localparam int STATUS_W           = 2;
    localparam int CMD_W              = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SELECT = 2'd2
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // main sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_READ,
        S_CMP
    } state_t;

    // scaling multiplier phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LO,
        PH_SUM
    } scale_phase_t;

endpackage

// File: rtl/rws_scale.sv
// Target scaling unit: floor(frac * total / 2^32) using one shared multiplier
// over two partial products. Depends on rws_pkg.
`timescale 1ns / 1ps

module rws_scale
    import rws_pkg::*;
#(
    parameter int SUM_W = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FRAC_W-1:0] frac,
    input  logic [SUM_W-1:0]  total,
    output logic              done,
    output logic [SUM_W-1:0]  target
);

    localparam int LO_W   = (SUM_W + 1) / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int PROD_W = FRAC_W + LO_W;
    localparam int ACC_W  = FRAC_W + SUM_W;

    scale_phase_t      phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  target_reg, target_next;

    logic [FRAC_W-1:0] mul_a;
    logic [LO_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_sum;

    // high half of total first, then low half
    assign mul_a   = (phase_reg == PH_IDLE) ? frac : frac_reg;
    assign mul_b   = (phase_reg == PH_IDLE) ? LO_W'(total[LO_W +: HI_W]) : total[LO_W-1:0];
    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_sum = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        done_next   = 1'b0;
        frac_next   = frac_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        target_next = target_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    frac_next  = frac;
                    prod_next  = prod;
                    phase_next = PH_LO;
                end
            end
            PH_LO:
            begin
                acc_next   = ACC_W'(prod_reg) << LO_W;
                prod_next  = prod;
                phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                target_next = acc_sum[FRAC_W +: SUM_W];
                done_next   = 1'b1;
                phase_next  = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg   <= frac_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        target_reg <= target_next;
    end

    assign done   = done_reg;
    assign target = target_reg;

endmodule

// File: rtl/rws_table.sv
// Cumulative-sum table: one write port, one registered read port.
// Depends on rws_pkg.
`timescale 1ns / 1ps

module rws_table
    import rws_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_POPULATION,
    parameter int SUM_W = 24
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [SUM_W-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [SUM_W-1:0]         rd_data
);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/roulette_wheel_selector.sv
// Roulette-wheel (fitness-proportional) selector top level.
// Depends on rws_pkg, rws_scale, rws_table.
`timescale 1ns / 1ps

// Commands are taken when start is high and busy is low. Clear, load and an
// unused code finish at once: the result beat (done high for one cycle) comes
// the cycle after the command, and busy stays low, so a new command may follow
// every cycle. A select on an empty table or zero total also answers the next
// cycle with status EMPTY. A real select stays busy through the scaling and k
// binary-search steps (k at most ceil(log2(entries)), 8 for a full 256-entry
// table). The shared multiplier that scales the random fraction by the running
// total forms the high partial product in the accept cycle, then the low
// product, then the sum; the scaler's registered done hands off, then one table
// read and one compare per step on the single read port. The result beat comes
// in the cycle busy drops. The receiver cannot stall: done is a one-cycle
// strobe and selected_index/status are only meaningful while it is high.
// Table contents are not cleared at reset or by the clear command; only
// entries written since the last clear are ever searched.

module roulette_wheel_selector
    import rws_pkg::*;
#(
    parameter int MAX_POPULATION = DEF_MAX_POPULATION,
    parameter int FITNESS_BITS   = DEF_FITNESS_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CMD_W-1:0]        command,
    input  logic [FITNESS_BITS-1:0] fitness_value,
    input  logic [FRAC_W-1:0]       random_fraction,
    output logic                    busy,
    output logic                    done,
    output logic [INDEX_W-1:0]      selected_index,
    output logic [STATUS_W-1:0]     status
);

    localparam int IDX_W = $clog2(MAX_POPULATION);
    localparam int CNT_W = $clog2(MAX_POPULATION + 1);
    // sums are exact: MAX_POPULATION entries of FITNESS_BITS each
    localparam int SUM_W = FITNESS_BITS + IDX_W;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    logic              done_reg, done_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    status_t           status_reg, status_next;

    logic              accept;
    logic [SUM_W-1:0]  sum_load;
    logic              wr_en;
    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid_calc;
    logic [SUM_W-1:0]  rd_data;
    logic              scale_start;
    logic              scale_done;
    logic [SUM_W-1:0]  target;
    logic              rd_gt;
    logic [IDX_W-1:0]  cmp_lo, cmp_hi;

    assign accept   = start && (state_reg == S_IDLE);
    assign sum_load = total_reg + SUM_W'(fitness_value);

    // midpoint of the current search window, floor
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[IDX_W:1];

    // first entry whose sum exceeds target lies in [lo, mid] or [mid+1, hi]
    assign rd_gt  = rd_data > target;
    assign cmp_lo = rd_gt ? lo_reg : IDX_W'(mid_reg + IDX_W'(1));
    assign cmp_hi = rd_gt ? mid_reg : hi_reg;

    rws_scale #(
        .SUM_W (SUM_W)
    ) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_start),
        .frac   (random_fraction),
        .total  (total_reg),
        .done   (scale_done),
        .target (target)
    );

    rws_table #(
        .DEPTH (MAX_POPULATION),
        .SUM_W (SUM_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (sum_load),
        .rd_addr (mid_calc),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        done_next   = 1'b0;
        index_next  = index_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        scale_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    index_next  = '0;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    case (command_t'(command))
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (count_reg == CNT_W'(MAX_POPULATION))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                total_next = sum_load;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_SELECT:
                        begin
                            if ((count_reg == '0) || (total_reg == '0))
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                lo_next     = '0;
                                hi_next     = IDX_W'(count_reg - CNT_W'(1));
                                scale_start = 1'b1;
                                state_next  = S_SCALE;
                            end
                        end
                        default:
                        begin
                            // unused code: plain ok beat
                        end
                    endcase
                end
            end
            S_SCALE:
            begin
                if (scale_done)
                begin
                    if (lo_reg == hi_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        index_next  = INDEX_W'({{INDEX_W{1'b0}}, lo_reg});
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // table read of mid_calc lands next cycle
                mid_next   = mid_calc;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                lo_next = cmp_lo;
                hi_next = cmp_hi;
                if (cmp_lo == cmp_hi)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    index_next  = INDEX_W'({{INDEX_W{1'b0}}, cmp_lo});
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        index_reg  <= index_next;
        status_reg <= status_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign selected_index = index_reg;
    assign status         = status_reg;

endmodule

// File: rtl/rws_checker.sv
// Port-level checks for roulette_wheel_selector, bound to the top level.
// Depends on rws_pkg and roulette_wheel_selector.
`timescale 1ns / 1ps

module rws_checker
    import rws_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic [CMD_W-1:0]    command,
    input logic                busy,
    input logic                done,
    input logic [INDEX_W-1:0]  selected_index,
    input logic [STATUS_W-1:0] status
);

    // result beat always ends the work; block is free in that cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // beats with an error status carry index zero
    a_err_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (selected_index == '0))
        else $error("nonzero index with error status");

    // non-select commands answer in the next cycle
    a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_SELECT)) |=> (done && !busy))
        else $error("missing beat after non-select command");

    // a select either answers at once or starts a search, never both
    a_select_go: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_SELECT)) |=> (busy != done))
        else $error("select neither answered nor started");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (.*);
